@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

    // Pool geometry
    localparam int MAP_BYTES  = 128;
    localparam int POOL_BITS  = MAP_BYTES * 8;
    localparam int WORD_W     = 32;
    localparam int POOL_WORDS = (MAP_BYTES + 3) / 4;
    localparam int BIT_AW     = 5;
    localparam int WORD_AW    = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
    localparam int IDX_W      = WORD_AW + BIT_AW;
    localparam int PTR_W      = WORD_AW + 1;

    // Bits of the last word that belong to the pool
    localparam int LAST_BITS = POOL_BITS - WORD_W * (POOL_WORDS - 1);
    localparam logic [WORD_W-1:0] LAST_MASK =
        WORD_W'((33'(1) << LAST_BITS) - 33'(1));

    localparam logic [PTR_W-1:0]   PTR_END   = PTR_W'(POOL_WORDS);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(POOL_WORDS - 1);

    // Id and status fields
    localparam int ID_W   = 16;
    localparam int ST_W   = 2;
    localparam int DATA_W = 24;
    localparam logic [ID_W-1:0] POOL_SIZE_ID = ID_W'(POOL_BITS);
    localparam logic [ID_W-1:0] BASE_RESET   = ID_W'(1);

    typedef enum logic [ST_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_RANGE     = 2'd2
    } status_t;

    typedef enum logic {
        UOP_FIND,
        UOP_CLEAR
    } uop_t;

    // Bitmap memory port
    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } mem_req_t;

    // Shared word unit
    typedef struct packed {
        uop_t              op;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] mask;
        logic [BIT_AW-1:0] pos;
    } unit_req_t;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] pos;
        logic [WORD_W-1:0] word;
    } unit_rsp_t;

endpackage

@@ rtl/bpa_map_mem.sv @@
module bpa_map_mem
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0]     mem [POOL_WORDS];
    logic [POOL_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]     rd_word_reg;
    logic                  rd_valid_reg;

    // Store words and register the read data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // Track written words; an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ rtl/bpa_bit_unit.sv @@
module bpa_bit_unit
    import bpa_pkg::*;
(
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] low_bit;
    logic [BIT_AW-1:0] low_pos;

    // Isolate the lowest free bit inside the pool mask
    assign free_bits = ~req.word & req.mask;
    assign low_bit   = free_bits & (~free_bits + WORD_W'(1));

    // Encode the one-hot position
    always_comb
    begin
        low_pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low_bit[i])
            begin
                low_pos = low_pos | BIT_AW'(i);
            end
        end
    end

    // Set the found bit or clear the requested one
    always_comb
    begin
        rsp.found = |free_bits;
        rsp.pos   = low_pos;
        case (req.op)
            UOP_FIND:  rsp.word = req.word | low_bit;
            UOP_CLEAR: rsp.word = req.word & ~(WORD_W'(1) << req.pos);
            default:   rsp.word = req.word;
        endcase
    end

endmodule

@@ rtl/bitmap_pid_allocator.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: release_id[15:0]; tuser: mode
// m_*       out  m_tvalid/m_tready  tdata: granted_id[15:0], status[17:16], zero[23:18]
// cfg_*     in   cfg_valid/cfg_ready cfg_data: id_base[15:0]
//
// Allocate scans the bitmap from word 0 until a free bit is found or the last word is checked:
// the bitmap RAM read port delivers one word per cycle to the shared find-first-free unit.
// Release is one read, one clearing write and one result load; a release outside the
// pool goes straight to the result load. The sequencer then returns to idle.
// One request is in work at a time; s_tready is high only while the sequencer is idle.
// The result register holds a finished result while m_tready is low; a new request is
// taken meanwhile, and its result waits until the register frees.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
module bitmap_pid_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ID_W-1:0]   s_tdata,   // release_id
    input  logic              s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // granted_id, status, zero pad
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ID_W-1:0]   cfg_data   // id_base
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL_RD,
        ST_REL_WR,
        ST_RESULT
    } state_t;

    state_t             state_reg,    state_next;
    logic [PTR_W-1:0]   ptr_reg,      ptr_next;
    logic               live_reg,     live_next;
    logic [WORD_AW-1:0] live_word_reg, live_word_next;
    logic [IDX_W-1:0]   idx_reg,      idx_next;
    logic [ID_W-1:0]    base_reg,     base_next;
    logic [ID_W-1:0]    res_id_reg,   res_id_next;
    status_t            res_st_reg,   res_st_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]  m_tdata_reg,  m_tdata_next;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] rd_data;
    unit_req_t         unit_req;
    unit_rsp_t         unit_rsp;
    logic [ID_W:0]     rel_diff;
    logic              rel_in_range;
    logic              in_accept;
    logic              out_free;

    bpa_map_mem u_map_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    bpa_bit_unit u_bit_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Offset of the released id from the base
    assign rel_diff     = {1'b0, s_tdata} - {1'b0, base_reg};
    assign rel_in_range = !rel_diff[ID_W] && (rel_diff[ID_W-1:0] < POOL_SIZE_ID);

    // Feed the shared unit from the word just read
    always_comb
    begin
        unit_req.op   = (state_reg == ST_REL_WR) ? UOP_CLEAR : UOP_FIND;
        unit_req.word = rd_data;
        unit_req.mask = (live_word_reg == LAST_WORD) ? LAST_MASK : '1;
        unit_req.pos  = idx_reg[BIT_AW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        live_next      = 1'b0;
        live_word_next = live_word_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = '0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = live_word_reg;
        mem_req.wr_data = unit_rsp.word;

        if (cfg_valid && cfg_ready)
        begin
            base_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_id_next = '0;
                    res_st_next = STAT_OK;
                    if (!s_tuser)
                    begin
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (rel_in_range)
                    begin
                        idx_next   = rel_diff[IDX_W-1:0];
                        state_next = ST_REL_RD;
                    end
                    else
                    begin
                        res_st_next = STAT_RANGE;
                        state_next  = ST_RESULT;
                    end
                end
            end

            ST_SCAN:
            begin
                // Stream word reads while checking the word that came back
                if (ptr_reg < PTR_END)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[WORD_AW-1:0];
                    ptr_next        = ptr_reg + PTR_W'(1);
                    live_next       = 1'b1;
                    live_word_next  = ptr_reg[WORD_AW-1:0];
                end
                if (live_reg)
                begin
                    if (unit_rsp.found)
                    begin
                        mem_req.wr_en = 1'b1;
                        res_id_next   = base_reg + ID_W'({live_word_reg, unit_rsp.pos});
                        live_next     = 1'b0;
                        state_next    = ST_RESULT;
                    end
                    else if (live_word_reg == LAST_WORD)
                    begin
                        res_st_next = STAT_EXHAUSTED;
                        live_next   = 1'b0;
                        state_next  = ST_RESULT;
                    end
                end
            end

            ST_REL_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg[IDX_W-1:BIT_AW];
                state_next      = ST_REL_WR;
            end

            ST_REL_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[IDX_W-1:BIT_AW];
                state_next      = ST_RESULT;
            end

            ST_RESULT:
            begin
                // Hold until the result register frees
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = DATA_W'({res_st_reg, res_id_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            live_reg      <= 1'b0;
            live_word_reg <= '0;
            idx_reg       <= '0;
            base_reg      <= BASE_RESET;
            res_id_reg    <= '0;
            res_st_reg    <= STAT_OK;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            live_reg      <= live_next;
            live_word_reg <= live_word_next;
            idx_reg       <= idx_next;
            base_reg      <= base_next;
            res_id_reg    <= res_id_next;
            res_st_reg    <= res_st_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    // Bitmap writes come only from a successful scan or a release
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == ST_SCAN || state_reg == ST_REL_WR))
        else $error("bitmap written outside scan or release");

    // A failed request never carries an id
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ID_W+ST_W-1:ID_W] != STAT_OK) |-> (m_tdata[ID_W-1:0] == '0))
        else $error("failed request returned an id");

    // An accepted request keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input reopened right after accept");

    // A pending result is not overwritten
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && m_tvalid && !m_tready) |=>
            (state_reg == ST_RESULT && $stable(m_tdata)))
        else $error("pending result overwritten");

    // The scan pointer stops at the pool end
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_END)
        else $error("scan pointer past pool end");
`endif

endmodule

@@ bench/tb_bitmap_pid_allocator.sv @@
`timescale 1ns / 100ps

module tb_bitmap_pid_allocator;
    import bpa_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [ID_W-1:0] granted;
        status_t         status;
    } pid_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [ID_W-1:0]   s_tdata;   // release_id
    logic              s_tuser;   // mode
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // granted_id[15:0], status[17:16], zero pad
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ID_W-1:0]   cfg_data;  // id_base

    // Shadow copy of the allocator state
    logic [POOL_BITS-1:0] id_taken;
    logic [ID_W-1:0]      id_base_q;

    pid_result_t pending_results[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int grants_seen     = 0;
    int exhausted_seen  = 0;
    int range_seen      = 0;
    int releases_ok     = 0;
    int base_writes     = 0;

    // Sender and receiver controls
    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;
    int burst_left   = 0;
    int hold_off_len = 0;
    int idle_cycles  = 0;

    bitmap_pid_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Compute the result of one request and advance the shadow bitmap
    function automatic pid_result_t predict_pid_result(req_kind_t kind, logic [ID_W-1:0] rel);
        pid_result_t res;
        int          idx;
        int          i;
        int unsigned offset;
        res.granted = '0;
        res.status  = STAT_OK;
        if (kind == REQ_ALLOC)
        begin
            idx = -1;
            for (i = 0; i < POOL_BITS; i++)
            begin
                if (idx < 0 && !id_taken[i])
                    idx = i;
            end
            if (idx < 0)
            begin
                res.status = STAT_EXHAUSTED;
                exhausted_seen++;
            end
            else
            begin
                id_taken[idx] = 1'b1;
                // ids past 16 bits wrap
                res.granted = ID_W'(idx + int'(id_base_q));
                grants_seen++;
            end
        end
        else
        begin
            offset = 32'(rel) - 32'(id_base_q);
            if (rel < id_base_q || offset >= POOL_BITS)
            begin
                res.status = STAT_RANGE;
                range_seen++;
            end
            else
            begin
                // releasing a free id leaves it free
                id_taken[offset] = 1'b0;
                releases_ok++;
            end
        end
        return res;
    endfunction

    // Any id currently held in the pool, or a random one when none is held
    function automatic logic [ID_W-1:0] pick_taken_id();
        int start;
        int k;
        int i;
        start = $urandom_range(POOL_BITS - 1, 0);
        for (k = 0; k < POOL_BITS; k++)
        begin
            i = (start + k) % POOL_BITS;
            if (id_taken[i])
                return ID_W'(i + int'(id_base_q));
        end
        return ID_W'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // Offer one request, hold it until accepted, then predict its result
    task automatic send_request(req_kind_t kind, logic [ID_W-1:0] rel);
        int gap;
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(10, 1);
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(16, 1);
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = rel;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
        pending_results.push_back(predict_pid_result(kind, rel));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write id_base while the block is idle
    task automatic write_id_base(logic [ID_W-1:0] base);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = base;
        do
            @(posedge clk);
        while (!cfg_ready);
        id_base_q = base;
        base_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reset base of 1: first-free order, reuse, free-id release, range edges
    task automatic test_reset_base();
        send_request(REQ_ALLOC, 16'h0000);
        send_request(REQ_ALLOC, 16'hFFFF);
        send_request(REQ_ALLOC, 16'h5A5A);
        send_request(REQ_RELEASE, 16'd2);
        send_request(REQ_ALLOC, 16'hA5A5);
        send_request(REQ_RELEASE, 16'd2);
        send_request(REQ_RELEASE, 16'd2);
        send_request(REQ_RELEASE, 16'd0);
        send_request(REQ_RELEASE, ID_W'(1 + POOL_BITS));
        send_request(REQ_RELEASE, ID_W'(POOL_BITS));
        send_request(REQ_RELEASE, 16'hFFFF);
        wait_drain();
    endtask

    // Lowest and highest base in range
    task automatic test_base_extremes();
        write_id_base(16'd0);
        send_request(REQ_RELEASE, 16'd0);
        send_request(REQ_ALLOC, 16'h0000);
        send_request(REQ_RELEASE, ID_W'(POOL_BITS - 1));
        send_request(REQ_RELEASE, ID_W'(POOL_BITS));
        write_id_base(ID_W'(65536 - POOL_BITS));
        send_request(REQ_RELEASE, 16'hFFFF);
        send_request(REQ_RELEASE, ID_W'(65535 - POOL_BITS));
        send_request(REQ_ALLOC, 16'h1234);
        wait_drain();
    endtask

    // Base near the top of the id space: granted ids wrap past 16 bits
    task automatic test_id_wrap();
        int k;
        write_id_base(16'hFFFA);
        for (k = 0; k < 8; k++)
            send_request(REQ_ALLOC, ID_W'($urandom));
        send_request(REQ_RELEASE, 16'h0002);
        wait_drain();
    endtask

    // Mixed traffic: grants, releases of held ids, and random or edge ids
    task automatic test_random_traffic(int n_items, int alloc_pct, int noise_pct);
        int          k;
        int unsigned r;
        int unsigned edge_pick;
        for (k = 0; k < n_items; k++)
        begin
            // pause once until the block has drained
            if (k == n_items / 2)
                wait_drain();
            r = $urandom_range(99, 0);
            if (r < alloc_pct)
                send_request(REQ_ALLOC, ID_W'($urandom));
            else if (r < alloc_pct + noise_pct)
            begin
                edge_pick = $urandom_range(5, 0);
                case (edge_pick)
                    0: send_request(REQ_RELEASE, id_base_q - 16'd1);
                    1: send_request(REQ_RELEASE, ID_W'(int'(id_base_q) + POOL_BITS));
                    2: send_request(REQ_RELEASE, ID_W'(int'(id_base_q) + POOL_BITS - 1));
                    default: send_request(REQ_RELEASE, ID_W'($urandom));
                endcase
            end
            else
                send_request(REQ_RELEASE, pick_taken_id());
        end
        wait_drain();
    endtask

    // Hold the output off long enough that the block stops taking requests
    task automatic test_output_backpressure();
        int k;
        tx_gaps      = 1'b0;
        hold_off_len = LONG_HOLD;
        for (k = 0; k < 16; k++)
            send_request((k % 3 != 0) ? REQ_ALLOC : REQ_RELEASE, pick_taken_id());
        tx_gaps = 1'b1;
        wait_drain();
    endtask

    // Fill the pool, allocate past full, churn near full for deep scans
    task automatic test_pool_exhaustion();
        int k;
        write_id_base(16'd100);
        while ($countones(id_taken) < POOL_BITS)
            send_request(REQ_ALLOC, ID_W'($urandom));
        for (k = 0; k < 3; k++)
            send_request(REQ_ALLOC, ID_W'($urandom));
        for (k = 0; k < 40; k++)
        begin
            send_request(REQ_RELEASE, pick_taken_id());
            send_request(REQ_ALLOC, ID_W'($urandom));
        end
        send_request(REQ_RELEASE, ID_W'(int'(id_base_q) + POOL_BITS));
        send_request(REQ_ALLOC, 16'h0000);
        wait_drain();
    endtask

    // Receiver: alternate ready and stall stretches, honor a long hold-off request
    initial
    begin : rx_pattern
        int  hold_cnt;
        int  phase_left;
        bit  ready_phase;
        m_tready    = 1'b0;
        phase_left  = 0;
        ready_phase = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0)
            begin
                hold_cnt     = hold_off_len;
                hold_off_len = 0;
                m_tready     = 1'b0;
                while (hold_cnt > 1)
                begin
                    @(negedge clk);
                    hold_cnt--;
                end
            end
            else if (!rx_stalls)
                m_tready = 1'b1;
            else
            begin
                if (phase_left == 0)
                begin
                    ready_phase = !ready_phase;
                    phase_left  = ready_phase ? $urandom_range(12, 1) : $urandom_range(8, 1);
                end
                phase_left--;
                m_tready = ready_phase;
            end
        end
    end

    // Compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin
        pid_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, granted_id",
                                32'(m_tdata[ID_W-1:0]), 32'(0));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[ID_W-1:0] !== want.granted)
                    report_mismatch("granted_id", 32'(m_tdata[ID_W-1:0]),
                                    32'(want.granted));
                if (m_tdata[ID_W +: ST_W] !== want.status)
                    report_mismatch("status", 32'(m_tdata[ID_W +: ST_W]),
                                    32'(want.status));
                if (m_tdata[DATA_W-1:ID_W+ST_W] !== '0)
                    report_mismatch("pad bits", 32'(m_tdata[DATA_W-1:ID_W+ST_W]), 32'(0));
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d results still expected", pending_results.size());
                $display("bitmap_pid_allocator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = REQ_ALLOC;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        id_taken  = '0;
        id_base_q = BASE_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_base();
        test_base_extremes();
        test_id_wrap();

        write_id_base(16'd1);
        test_random_traffic(140, 55, 15);

        // stretch with no idling on either side
        write_id_base(ID_W'($urandom_range(65536 - POOL_BITS, 0)));
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        test_random_traffic(130, 60, 10);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;

        test_output_backpressure();

        write_id_base(ID_W'(65536 - POOL_BITS));
        test_random_traffic(140, 65, 15);

        write_id_base(16'd0);
        test_random_traffic(130, 80, 10);

        test_pool_exhaustion();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d grants, %0d exhausted, %0d out-of-range, %0d releases)",
                 requests_sent, grants_seen, exhausted_seen, range_seen, releases_ok);
        $display("checked %0d results over %0d id_base settings, %0d mismatches",
                 results_checked, base_writes + 1, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bitmap_pid_allocator regression: pass");
        else
            $display("bitmap_pid_allocator regression: fail");
        $finish;
    end

endmodule
